// ===== rtl/gwwb_pkg.sv =====
// ----------------------------------------------------------------------------
// gwwb_pkg: shared types and constants
// Widths, register indexes, reset values and the structs that pass between
// the queue front end, the correction back end and the gain divider.
// ----------------------------------------------------------------------------
package gwwb_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 28;
  localparam int TOT_W      = 30;   // sum of three channel sums
  localparam int DEN_W      = 30;   // three times one channel sum
  localparam int SCALE_W    = 24;   // unsigned Q8.16 gain
  localparam int BRIGHT_W   = 9;
  localparam int CONTRAST_W = 12;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CONTRAST   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AWB_ENABLE = 2'd2;

  localparam logic signed [BRIGHT_W-1:0] BRIGHT_RST   = -9'sd35;
  localparam logic [CONTRAST_W-1:0]      CONTRAST_RST = 12'd320;
  localparam logic                       AWB_RST      = 1'b1;

  localparam logic [SUM_W-1:0]   SUM_MAX   = 28'hFFF_FFFF;
  localparam logic [SCALE_W-1:0] SCALE_ONE = 24'h01_0000;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 24'hFF_FFFF;

  // Item kind after classification at the front end
  typedef enum logic [1:0] {
    OP_GATHER  = 2'd0,
    OP_RESTART = 2'd1,
    OP_CORRECT = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } item_t;

  typedef struct packed {
    logic signed [BRIGHT_W-1:0] brightness;
    logic [CONTRAST_W-1:0]      contrast_q8;
    logic                       awb_enable;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [TOT_W-1:0] total;
    logic [SUM_W-1:0] chan;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SCALE_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/gwwb_front.sv =====
// ----------------------------------------------------------------------------
// gwwb_front: input acceptance and item queue
// Classifies each accepted item and holds it in a small register queue
// until the back end takes it.
// ----------------------------------------------------------------------------
module gwwb_front #(
  parameter int DEPTH = gwwb_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic                       in_restart,
  input  logic [gwwb_pkg::PIX_W-1:0] in_blue,
  input  logic [gwwb_pkg::PIX_W-1:0] in_green,
  input  logic [gwwb_pkg::PIX_W-1:0] in_red,
  input  logic                       pop,
  output logic                       head_valid,
  output gwwb_pkg::item_t            head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gwwb_pkg::item_t  q_mem [DEPTH];
  gwwb_pkg::item_t  item;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;

  always_comb begin
    if (in_cmd) begin
      item.op = gwwb_pkg::OP_CORRECT;
    end else if (in_restart) begin
      item.op = gwwb_pkg::OP_RESTART;
    end else begin
      item.op = gwwb_pkg::OP_GATHER;
    end
    item.blue  = in_blue;
    item.green = in_green;
    item.red   = in_red;
  end

  assign in_ready   = (cnt_r != CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_mem[rd_ptr_r];
  assign push       = in_valid && in_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== rtl/gwwb_div.sv =====
// ----------------------------------------------------------------------------
// gwwb_div: gain divider
// Computes total*2^16 / (3*chan), one quotient bit per cycle, saturated to
// the Q8.16 range; a zero channel sum gives zero.
// ----------------------------------------------------------------------------
module gwwb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gwwb_pkg::div_req_t req,
  output gwwb_pkg::div_rsp_t rsp
);

  localparam int QW  = gwwb_pkg::SCALE_W;
  localparam int CW  = $clog2(QW);
  localparam int DW  = gwwb_pkg::DEN_W;
  localparam int TW  = gwwb_pkg::TOT_W;
  localparam int SW  = gwwb_pkg::SUM_W;
  localparam int LIM = SW + 10;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_DONE = 3'b100
  } dv_state_t;

  dv_state_t       state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [QW-1:0]   low_r, low_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;
  logic [LIM-1:0]  limit;

  // quotient overflows 24 bits exactly when total >= 768 * chan
  assign limit = LIM'({req.chan, 9'b0}) + LIM'({req.chan, 8'b0});
  assign trial = {rem_r, low_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    quo_nxt   = quo_r;
    case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          den_nxt = DW'(req.chan) + DW'({req.chan, 1'b0});
          rem_nxt = DW'(req.total[TW-1:8]);
          low_nxt = {req.total[7:0], 16'b0};
          cnt_nxt = CW'(QW - 1);
          quo_nxt = '0;
          if (req.chan == '0) begin
            state_nxt = DV_DONE;
          end else if (LIM'(req.total) >= limit) begin
            quo_nxt   = gwwb_pkg::SCALE_MAX;
            state_nxt = DV_DONE;
          end else begin
            state_nxt = DV_RUN;
          end
        end
      end
      DV_RUN: begin
        rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], fits};
        low_nxt = {low_r[QW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = DV_DONE;
        end
      end
      DV_DONE: begin
        state_nxt = DV_IDLE;
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = (state_r == DV_DONE);
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/gwwb_back.sv =====
// ----------------------------------------------------------------------------
// gwwb_back: statistics, gain update and pixel correction
// Takes items from the queue, keeps channel sums, refreshes gains through
// the divider and runs corrected pixels through two register stages.
// ----------------------------------------------------------------------------
module gwwb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gwwb_pkg::cfg_t             cfg,
  input  logic                       head_valid,
  input  gwwb_pkg::item_t            head,
  output logic                       pop,
  output gwwb_pkg::div_req_t         div_req,
  input  gwwb_pkg::div_rsp_t         div_rsp,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gwwb_pkg::PIX_W-1:0] out_blue,
  output logic [gwwb_pkg::PIX_W-1:0] out_green,
  output logic [gwwb_pkg::PIX_W-1:0] out_red
);

  localparam int PW = gwwb_pkg::PIX_W;
  localparam int SW = gwwb_pkg::SUM_W;
  localparam int GW = gwwb_pkg::SCALE_W;
  localparam int TW = gwwb_pkg::TOT_W;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef enum logic [2:0] {
    ST_PROC     = 3'b001,
    ST_DIV_GO   = 3'b010,
    ST_DIV_WAIT = 3'b100
  } bk_state_t;

  function automatic logic [SW-1:0] sat_acc(logic [SW-1:0] base, logic [PW-1:0] pix);
    logic [SW:0] s;
    s = {1'b0, base} + (SW+1)'(pix);
    return s[SW] ? gwwb_pkg::SUM_MAX : s[SW-1:0];
  endfunction

  function automatic logic [PW-1:0] apply_gain(logic [PW-1:0] p, logic [GW-1:0] g,
                                               logic en);
    logic [PW+GW-1:0] prod;
    prod = (PW+GW)'(p) * (PW+GW)'(g);
    if (!en) begin
      return p;
    end else if (|prod[PW+GW-1:24]) begin
      return '1;
    end else begin
      return prod[23:16];
    end
  endfunction

  function automatic logic [PW-1:0] apply_contrast(logic [PW-1:0] q,
                                                   logic [11:0] c,
                                                   logic signed [8:0] b);
    logic [19:0]        prod;
    logic signed [21:0] boff;
    logic signed [21:0] t;
    prod = 20'(q) * 20'(c);
    boff = {{5{b[8]}}, b, 8'b0};
    t    = $signed({2'b00, prod}) + boff;
    if (t[21]) begin
      return '0;
    end else if (|t[20:16]) begin
      return '1;
    end else begin
      return t[15:8];
    end
  endfunction

  bk_state_t       state_r, state_nxt;
  logic [1:0]      ch_r, ch_nxt;
  logic            pending_r, pending_nxt;
  logic [SW-1:0]   sum_b_r, sum_g_r, sum_r_r;
  logic [SW-1:0]   sum_b_nxt, sum_g_nxt, sum_r_nxt;
  logic [GW-1:0]   scl_b_r, scl_g_r, scl_r_r;
  logic [GW-1:0]   scl_b_nxt, scl_g_nxt, scl_r_nxt;
  logic            s1_valid_r, out_valid_r;
  logic [PW-1:0]   s1_b_r, s1_g_r, s1_r_r;
  logic [PW-1:0]   out_b_r, out_g_r, out_r_r;
  logic            head_gather, head_correct;
  logic            out_load, s1_open, s1_load, gather_pop;
  logic [SW-1:0]   chan_sel;
  logic [SW-1:0]   base_b, base_g, base_r;

  assign head_gather  = head_valid && (head.op != gwwb_pkg::OP_CORRECT);
  assign head_correct = head_valid && (head.op == gwwb_pkg::OP_CORRECT);
  assign out_load     = !out_valid_r || out_ready;
  assign s1_open      = !s1_valid_r || out_load;

  assign gather_pop = (state_r == ST_PROC) && head_gather;
  assign s1_load    = (state_r == ST_PROC) && head_correct && !pending_r && s1_open;
  assign pop        = gather_pop || s1_load;

  always_comb begin
    case (ch_r)
      CH_BLUE:  chan_sel = sum_b_r;
      CH_GREEN: chan_sel = sum_g_r;
      CH_RED:   chan_sel = sum_r_r;
      default:  chan_sel = sum_r_r;
    endcase
  end

  assign div_req.start = (state_r == ST_DIV_GO);
  assign div_req.total = TW'(sum_b_r) + TW'(sum_g_r) + TW'(sum_r_r);
  assign div_req.chan  = chan_sel;

  // restart clears the sums before this pixel is added
  assign base_b = (head.op == gwwb_pkg::OP_RESTART) ? '0 : sum_b_r;
  assign base_g = (head.op == gwwb_pkg::OP_RESTART) ? '0 : sum_g_r;
  assign base_r = (head.op == gwwb_pkg::OP_RESTART) ? '0 : sum_r_r;

  always_comb begin
    state_nxt   = state_r;
    ch_nxt      = ch_r;
    pending_nxt = pending_r;
    sum_b_nxt   = sum_b_r;
    sum_g_nxt   = sum_g_r;
    sum_r_nxt   = sum_r_r;
    scl_b_nxt   = scl_b_r;
    scl_g_nxt   = scl_g_r;
    scl_r_nxt   = scl_r_r;
    case (state_r)
      ST_PROC: begin
        if (gather_pop) begin
          sum_b_nxt   = sat_acc(base_b, head.blue);
          sum_g_nxt   = sat_acc(base_g, head.green);
          sum_r_nxt   = sat_acc(base_r, head.red);
          pending_nxt = 1'b1;
        end else if (head_correct && pending_r) begin
          ch_nxt    = CH_BLUE;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (ch_r)
            CH_BLUE:  scl_b_nxt = div_rsp.quo;
            CH_GREEN: scl_g_nxt = div_rsp.quo;
            default:  scl_r_nxt = div_rsp.quo;
          endcase
          if (ch_r == CH_RED) begin
            pending_nxt = 1'b0;
            state_nxt   = ST_PROC;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      default: begin
        state_nxt = ST_PROC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PROC;
      ch_r        <= CH_BLUE;
      pending_r   <= 1'b0;
      sum_b_r     <= '0;
      sum_g_r     <= '0;
      sum_r_r     <= '0;
      scl_b_r     <= gwwb_pkg::SCALE_ONE;
      scl_g_r     <= gwwb_pkg::SCALE_ONE;
      scl_r_r     <= gwwb_pkg::SCALE_ONE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      pending_r   <= pending_nxt;
      sum_b_r     <= sum_b_nxt;
      sum_g_r     <= sum_g_nxt;
      sum_r_r     <= sum_r_nxt;
      scl_b_r     <= scl_b_nxt;
      scl_g_r     <= scl_g_nxt;
      scl_r_r     <= scl_r_nxt;
      if (s1_open) begin
        s1_valid_r <= s1_load;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // stage one: white balance gain and clamp
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_b_r <= apply_gain(head.blue,  scl_b_r, cfg.awb_enable);
      s1_g_r <= apply_gain(head.green, scl_g_r, cfg.awb_enable);
      s1_r_r <= apply_gain(head.red,   scl_r_r, cfg.awb_enable);
    end
  end

  // stage two: contrast, brightness and clamp into the output register
  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_b_r <= apply_contrast(s1_b_r, cfg.contrast_q8, cfg.brightness);
      out_g_r <= apply_contrast(s1_g_r, cfg.contrast_q8, cfg.brightness);
      out_r_r <= apply_contrast(s1_r_r, cfg.contrast_q8, cfg.brightness);
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = out_b_r;
  assign out_green = out_g_r;
  assign out_red   = out_r_r;

endmodule

// ===== rtl/gray_world_white_balance_contrast_top.sv =====
// ----------------------------------------------------------------------------
// gray_world_white_balance_contrast_top: gray-world white balance with
// brightness and contrast
//
//   Channel   Dir  Handshake            Payload
//   in_*      in   in_tvalid/in_tready  tdata: blue, green, red; tuser: cmd, restart
//   out_*     out  out_tvalid/out_tready tdata: blue, green, red
//   cfg_*     in   cfg_we               cfg_addr, cfg_wdata (no read-back)
//
// Gather items are taken one per cycle while no gain refresh runs, and produce no
// output. Correct items are also taken one per cycle when stage one can load, and
// pass through stage one and the output register. The first correct item after a
// gather run waits for the divider on all three channels, one quotient bit per cycle.
// Reset (rst_n low, synchronous) empties the queue and pipeline, clears the sums,
// sets the gains to one and loads the configuration defaults. A stalled output
// holds the pipeline; the input queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module gray_world_white_balance_contrast_top #(
  parameter int QUEUE_DEPTH = gwwb_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // in_blue, in_green, in_red
  input  logic [1:0]                      in_tuser,   // cmd, restart
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // out_blue, out_green, out_red
  input  logic                            cfg_we,
  input  logic [gwwb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gwwb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gwwb_pkg::cfg_t     cfg_r, cfg_nxt;
  gwwb_pkg::item_t    head;
  gwwb_pkg::div_req_t div_req;
  gwwb_pkg::div_rsp_t div_rsp;
  logic               head_valid;
  logic               pop;
  logic [7:0]         res_blue, res_green, res_red;

  // Configuration registers; writes to an unused index are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        gwwb_pkg::REG_BRIGHTNESS: cfg_nxt.brightness  = $signed(cfg_wdata[8:0]);
        gwwb_pkg::REG_CONTRAST:   cfg_nxt.contrast_q8 = cfg_wdata;
        gwwb_pkg::REG_AWB_ENABLE: cfg_nxt.awb_enable  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness  <= gwwb_pkg::BRIGHT_RST;
      cfg_r.contrast_q8 <= gwwb_pkg::CONTRAST_RST;
      cfg_r.awb_enable  <= gwwb_pkg::AWB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: classify and queue each transfer
  gwwb_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser[0]),
    .in_restart (in_tuser[1]),
    .in_blue    (in_tdata[7:0]),
    .in_green   (in_tdata[15:8]),
    .in_red     (in_tdata[23:16]),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: sums, gain refresh and the correction pipeline
  gwwb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_blue   (res_blue),
    .out_green  (res_green),
    .out_red    (res_red)
  );

  // Shared divider for the three channel gains
  gwwb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tdata = {res_red, res_green, res_blue};

endmodule

// ===== rtl/gwwb_checker.sv =====
// ----------------------------------------------------------------------------
// gwwb_checker: port-level checks
// Watches the top level's ports; attached by the bind below.
// ----------------------------------------------------------------------------
module gwwb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result keeps its data until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // reset empties the correction pipeline
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // reset empties the queue, so input is open right after
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // just out of reset, with an idle input, no result may appear from nothing
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && !in_tvalid |=> !out_tvalid)
    else $error("result without transfer");

endmodule

bind gray_world_white_balance_contrast_top gwwb_checker u_gwwb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
